// ===== hdl/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and constants for the linear probing hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int Depth     = 256;
  localparam int IdxW      = 8;
  localparam int CntW      = 9;
  localparam int KeyW      = 32;
  localparam int ValW      = 32;
  localparam int QueueD    = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [CntW-1:0] BucketCountReset = 9'd256;
  localparam logic [1:0]      RegBucketCount   = 2'd0;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] found_value;
    logic [CntW-1:0] entry_count;
  } out_beat_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t             op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic [IdxW-1:0] home;
    logic [CntW-1:0] n;
  } req_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_REDUCE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_WRITE,
    BK_RESULT
  } back_state_t;

endpackage

// ===== hdl/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Key-value table with open addressing and linear probing behind an
// APB-style register port.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_       input      op, key, value
// out_      output     ok, found_value, entry_count
// cfg_      apb        bucket_count at address 0
//
// front reduces the key bit-serially and takes no new item until it has pushed the last one
// back reads and checks each probed bucket in turn, then writes the table and sets the result
// reset clears valid bits at once; no clearing pass
// either channel may stall; the queue holds two requests
// a waiting result holds the back at the end of its walk, not at its start
// ----------------------------------------------------------------------------
module linear_probe_hash_map import lphm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CntW-1:0] bucket_count_r;
  logic            q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  req_t            q_in_data, q_out_data;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RegBucketCount) ? 32'(bucket_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BucketCountReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegBucketCount) begin
      bucket_count_r <= cfg_pwdata[CntW-1:0];
    end
  end

  lphm_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .bucket_count(bucket_count_r),
    .q_valid(q_in_valid), .q_ready(q_in_ready), .q_data(q_in_data)
  );

  lphm_queue u_queue (
    .clk, .rst_n,
    .wr_valid(q_in_valid), .wr_ready(q_in_ready), .wr_data(q_in_data),
    .rd_valid(q_out_valid), .rd_ready(q_out_ready), .rd_data(q_out_data)
  );

  lphm_back u_back (
    .clk, .rst_n,
    .q_valid(q_out_valid), .q_ready(q_out_ready), .q_data(q_out_data),
    .out_valid, .out_ready, .out_data
  );

  // failed results never carry a value
  a_fval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.found_value == '0)
    else $error("found_value set on failed result");

  // entry count stays within the table
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= CntW'(Depth))
    else $error("entry count out of range");

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

endmodule

// ===== hdl/lphm_front.sv =====
// ----------------------------------------------------------------------------
// lphm_front
// Accepts requests, clamps the bucket count and reduces the key to its
// home bucket by restoring subtraction, one bit per cycle.
// ----------------------------------------------------------------------------
module lphm_front import lphm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_beat_t        in_data,
  input  logic [CntW-1:0] bucket_count,
  output logic            q_valid,
  input  logic            q_ready,
  output req_t            q_data
);

  front_state_t    state_r, state_nxt;
  req_t            req_r;
  logic [KeyW-1:0] rem_r;
  logic [5:0]      bit_r;
  logic [CntW-1:0] n_clamp;
  logic [KeyW:0]   trial;

  // clamp bucket count to 1..Depth
  always_comb begin
    n_clamp = bucket_count;
    if (bucket_count == '0) n_clamp = CntW'(1);
    if (bucket_count > CntW'(Depth)) n_clamp = CntW'(Depth);
  end

  // one restoring step of key modulo n
  always_comb begin
    trial = {rem_r, req_r.key[bit_r[4:0]]};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_IDLE:   if (in_valid) state_nxt = FR_REDUCE;
      FR_REDUCE: if (bit_r == 6'd0) state_nxt = FR_PUSH;
      FR_PUSH:   if (q_ready) state_nxt = FR_IDLE;
      default:   state_nxt = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == FR_IDLE);
    q_valid  = (state_r == FR_PUSH);
    q_data   = req_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == FR_IDLE && in_valid) begin
      req_r.op    <= op_t'(in_data.op);
      req_r.key   <= in_data.key;
      req_r.value <= in_data.value;
      req_r.n     <= n_clamp;
      req_r.home  <= '0;
      rem_r       <= '0;
      bit_r       <= 6'(KeyW - 1);
    end else if (state_r == FR_REDUCE) begin
      if (trial >= (KeyW+1)'(req_r.n)) begin
        rem_r <= KeyW'(trial - (KeyW+1)'(req_r.n));
        if (bit_r == 6'd0) req_r.home <= IdxW'(trial - (KeyW+1)'(req_r.n));
      end else begin
        rem_r <= KeyW'(trial);
        if (bit_r == 6'd0) req_r.home <= IdxW'(trial);
      end
      bit_r <= bit_r - 6'd1;
    end
  end

endmodule

// ===== hdl/lphm_queue.sv =====
// ----------------------------------------------------------------------------
// lphm_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module lphm_queue import lphm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  req_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output req_t rd_data
);

  req_t       mem_r [QueueD];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'(QueueD));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/lphm_back.sv =====
// ----------------------------------------------------------------------------
// lphm_back
// Walks the probe sequence over the bucket memories, applies the request
// and holds the result register.
// ----------------------------------------------------------------------------
module lphm_back import lphm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  req_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [KeyW-1:0] key_mem [Depth];
  logic [ValW-1:0] val_mem [Depth];
  logic [Depth-1:0] used_r;
  logic [Depth-1:0] tomb_r;

  back_state_t     state_r, state_nxt;
  req_t            req_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] step_r;
  logic            have_free_r;
  logic [IdxW-1:0] free_r;
  logic [KeyW-1:0] rkey_r;
  logic [ValW-1:0] rval_r;
  logic            rnu_r, rtomb_r;
  logic [CntW-1:0] live_r;
  logic            ok_r;
  logic [ValW-1:0] fval_r;
  logic            res_valid_r;
  logic [IdxW-1:0] idx_next;
  logic            walk_end, hit, stop;

  assign idx_next = ((CntW)'(idx_r) + CntW'(1) == req_r.n) ? '0 : idx_r + IdxW'(1);
  assign walk_end = (step_r + CntW'(1) == req_r.n);
  assign hit      = !rnu_r && !rtomb_r && (rkey_r == req_r.key);
  assign stop     = rnu_r || hit || walk_end;

  // next state; a waiting result holds the walk at its last bucket
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (q_valid) state_nxt = BK_READ;
      BK_READ:   state_nxt = BK_CHECK;
      BK_CHECK: begin
        if (!stop) state_nxt = BK_READ;
        else if (!res_valid_r) state_nxt = BK_WRITE;
      end
      BK_WRITE:  state_nxt = BK_RESULT;
      BK_RESULT: state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready              = (state_r == BK_IDLE);
    out_valid            = res_valid_r;
    out_data.ok          = ok_r;
    out_data.found_value = fval_r;
    out_data.entry_count = live_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // bucket memory read, registered
  always_ff @(posedge clk) begin
    rkey_r <= key_mem[idx_r];
    rval_r <= val_mem[idx_r];
  end

  // walk control and payload
  always_ff @(posedge clk) begin
    priority if (state_r == BK_IDLE && q_valid) begin
      req_r       <= q_data;
      idx_r       <= q_data.home;
      step_r      <= '0;
      have_free_r <= 1'b0;
      free_r      <= '0;
    end else if (state_r == BK_READ) begin
      rnu_r   <= !used_r[idx_r];
      rtomb_r <= tomb_r[idx_r];
    end else if (state_r == BK_CHECK) begin
      if (!have_free_r && (rnu_r || rtomb_r)) begin
        have_free_r <= 1'b1;
        free_r      <= idx_r;
      end
      if (!stop) begin
        idx_r  <= idx_next;
        step_r <= step_r + CntW'(1);
      end
    end
  end

  // apply and build result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      tomb_r      <= '0;
      live_r      <= '0;
      res_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      fval_r      <= '0;
    end else begin
      if (out_valid && out_ready) res_valid_r <= 1'b0;
      if (state_r == BK_WRITE) begin
        ok_r   <= 1'b0;
        fval_r <= '0;
        unique case (req_r.op)
          OP_INSERT: begin
            if (live_r < req_r.n && !hit && (have_free_r || rnu_r || rtomb_r)) begin
              ok_r   <= 1'b1;
              live_r <= live_r + CntW'(1);
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              ok_r   <= 1'b1;
              fval_r <= rval_r;
            end
          end
          OP_REMOVE: begin
            if (hit && live_r != '0) begin
              ok_r          <= 1'b1;
              live_r        <= live_r - CntW'(1);
              tomb_r[idx_r] <= 1'b1;
            end
          end
          OP_NONE: ;
          default: ;
        endcase
        if (req_r.op == OP_INSERT && live_r < req_r.n && !hit) begin
          if (have_free_r) begin
            used_r[free_r] <= 1'b1;
            tomb_r[free_r] <= 1'b0;
          end else if (rnu_r || rtomb_r) begin
            used_r[idx_r] <= 1'b1;
            tomb_r[idx_r] <= 1'b0;
          end
        end
      end
      if (state_r == BK_RESULT) res_valid_r <= 1'b1;
    end
  end

  // key and value memories
  always_ff @(posedge clk) begin
    if (state_r == BK_WRITE && req_r.op == OP_INSERT && live_r < req_r.n && !hit) begin
      if (have_free_r) begin
        key_mem[free_r] <= req_r.key;
        val_mem[free_r] <= req_r.value;
      end else if (rnu_r || rtomb_r) begin
        key_mem[idx_r] <= req_r.key;
        val_mem[idx_r] <= req_r.value;
      end
    end
  end

endmodule
